>>> src/xmr_pkg.sv
// Package: shared types and constants of the XMODEM-1K receiver
package xmr_pkg;
  localparam int LONG_PAYLOAD  = 1024;
  localparam int SHORT_PAYLOAD = 128;

  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_BYTE  = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  localparam logic [7:0] B_SOH  = 8'h01;
  localparam logic [7:0] B_STX  = 8'h02;
  localparam logic [7:0] B_EOT  = 8'h04;
  localparam logic [7:0] B_ACK  = 8'h06;
  localparam logic [7:0] B_NAK  = 8'h15;
  localparam logic [7:0] B_CAN  = 8'h18;
  localparam logic [7:0] B_POLL = 8'h43;

  localparam logic [2:0] ST_NONE    = 3'd0;
  localparam logic [2:0] ST_NEW     = 3'd1;
  localparam logic [2:0] ST_DUP     = 3'd2;
  localparam logic [2:0] ST_REJECT  = 3'd3;
  localparam logic [2:0] ST_TIMEOUT = 3'd4;

  localparam logic [2:0] RA_POLL     = 3'd0;
  localparam logic [2:0] RA_WAIT     = 3'd1;
  localparam logic [2:0] RA_PKT_GAP  = 3'd2;
  localparam logic [2:0] RA_CHAR_GAP = 3'd3;
  localparam logic [2:0] RA_RETRY    = 3'd4;

  localparam logic [19:0] GAP_MAX  = 20'hFFFFF;
  localparam logic [20:0] POLL_MAX = 21'h1FFFFF;

  typedef enum logic [1:0] {CMD_START, CMD_BYTE, CMD_TICK, CMD_NOP} cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] b;
  } item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       data_valid;
    logic [7:0] data_byte;
    logic [9:0] data_offset;
    logic [2:0] packet_status;
    logic       packet_long;
    logic       session_done;
    logic       session_failed;
  } result_t;

  typedef struct packed {
    logic [15:0] poll_interval;
    logic [19:0] start_wait_limit;
    logic [15:0] packet_gap_timeout;
    logic [15:0] char_gap_timeout;
    logic [3:0]  retry_limit;
  } cfg_t;

  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    end
    return c;
  endfunction
endpackage

>>> src/xmodem_1k_receiver.sv
// Top level: XMODEM-1K receiver with APB register port
// An input transfer reaches its result through the request queue and then the output register.
// Throughput: one request per cycle while out_stall is low; the back end session logic is combinational.
// A two-entry request queue and the output register let each side stall on its own.
// Reset: synchronous active-low rst_n clears queue, session state and registers to defaults.
module xmodem_1k_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_tx_valid,
  output logic [7:0]  out_tx_byte,
  output logic        out_data_valid,
  output logic [7:0]  out_data_byte,
  output logic [9:0]  out_data_offset,
  output logic [2:0]  out_packet_status,
  output logic        out_packet_long,
  output logic        out_session_done,
  output logic        out_session_failed,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  xmr_pkg::cfg_t cfg_r;
  logic q_valid, q_take;
  xmr_pkg::item_t q_item;
  xmr_pkg::result_t res;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.poll_interval <= 16'd3000;
      cfg_r.start_wait_limit <= 20'd60000;
      cfg_r.packet_gap_timeout <= 16'd500;
      cfg_r.char_gap_timeout <= 16'd100;
      cfg_r.retry_limit <= 4'd10;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr[4:2])
        xmr_pkg::RA_POLL:     cfg_r.poll_interval <= cfg_pwdata[15:0];
        xmr_pkg::RA_WAIT:     cfg_r.start_wait_limit <= cfg_pwdata[19:0];
        xmr_pkg::RA_PKT_GAP:  cfg_r.packet_gap_timeout <= cfg_pwdata[15:0];
        xmr_pkg::RA_CHAR_GAP: cfg_r.char_gap_timeout <= cfg_pwdata[15:0];
        xmr_pkg::RA_RETRY:    cfg_r.retry_limit <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      xmr_pkg::RA_POLL:     cfg_prdata = {16'd0, cfg_r.poll_interval};
      xmr_pkg::RA_WAIT:     cfg_prdata = {12'd0, cfg_r.start_wait_limit};
      xmr_pkg::RA_PKT_GAP:  cfg_prdata = {16'd0, cfg_r.packet_gap_timeout};
      xmr_pkg::RA_CHAR_GAP: cfg_prdata = {16'd0, cfg_r.char_gap_timeout};
      xmr_pkg::RA_RETRY:    cfg_prdata = {28'd0, cfg_r.retry_limit};
      default:              cfg_prdata = '0;
    endcase
  end

  xmr_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_req_type, .in_rx_byte,
    .q_valid, .q_item, .q_take
  );

  xmr_back u_back (
    .clk, .rst_n, .cfg(cfg_r), .q_valid, .q_item, .q_take,
    .out_valid, .out_stall, .out_res(res)
  );

  assign out_tx_valid = res.tx_valid;
  assign out_tx_byte = res.tx_byte;
  assign out_data_valid = res.data_valid;
  assign out_data_byte = res.data_byte;
  assign out_data_offset = res.data_offset;
  assign out_packet_status = res.packet_status;
  assign out_packet_long = res.packet_long;
  assign out_session_done = res.session_done;
  assign out_session_failed = res.session_failed;
endmodule

>>> src/xmr_front.sv
// Front end: accepts requests, classifies them and queues them two deep
module xmr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_req_type,
  input  logic [7:0]        in_rx_byte,
  output logic              q_valid,
  output xmr_pkg::item_t    q_item,
  input  logic              q_take
);
  xmr_pkg::item_t mem_r [2];
  logic [1:0] cnt_r;
  logic       rd_r, wr_r;
  xmr_pkg::item_t it;
  logic push, pop;

  always_comb begin
    case (in_req_type)
      xmr_pkg::REQ_START: it.cmd = xmr_pkg::CMD_START;
      xmr_pkg::REQ_BYTE:  it.cmd = xmr_pkg::CMD_BYTE;
      xmr_pkg::REQ_TICK:  it.cmd = xmr_pkg::CMD_TICK;
      default:            it.cmd = xmr_pkg::CMD_NOP;
    endcase
    it.b = in_rx_byte;
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt_r != 2'd0);
  assign pop = q_valid && q_take;
  assign q_item = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r <= 1'b0;
      wr_r <= 1'b0;
    end else begin
      if (push) wr_r <= !wr_r;
      if (pop) rd_r <= !rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) mem_r[wr_r] <= it;
  end
endmodule

>>> src/xmr_back.sv
// Back end: session state machine, packet checks, CRC and output register
module xmr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  xmr_pkg::cfg_t     cfg,
  input  logic              q_valid,
  input  xmr_pkg::item_t    q_item,
  output logic              q_take,
  output logic              out_valid,
  input  logic              out_stall,
  output xmr_pkg::result_t  out_res
);
  typedef enum logic [1:0] {PH_OFF, PH_POLL, PH_RECV} phase_t;

  phase_t phase_r, phase_nxt;
  logic [10:0] bc_r, bc_nxt;
  logic lp_r, lp_nxt;
  logic [7:0] hc_r, hc_nxt, hs_r, hs_nxt, hi_r, hi_nxt, es_r, es_nxt;
  logic [19:0] gt_r, gt_nxt;
  logic [20:0] pt_r, pt_nxt;
  logic [3:0] tc_r, tc_nxt, ec_r, ec_nxt;
  logic [15:0] rc_r, rc_nxt, kc_r, kc_nxt;
  logic ov_r;
  xmr_pkg::result_t res_r, o;

  assign q_take = !ov_r || !out_stall;
  assign out_valid = ov_r;
  assign out_res = res_r;

  wire logic fire = q_valid && q_take;

  always_comb begin
    logic [10:0] plen, off;
    logic [21:0] psum;
    logic [8:0] ssum;
    logic bad, poc, nak, ack, cancel;
    phase_nxt = phase_r; bc_nxt = bc_r; lp_nxt = lp_r;
    hc_nxt = hc_r; hs_nxt = hs_r; hi_nxt = hi_r; es_nxt = es_r;
    gt_nxt = gt_r; pt_nxt = pt_r; tc_nxt = tc_r; ec_nxt = ec_r;
    rc_nxt = rc_r; kc_nxt = kc_r;
    o = '0;
    poc = 1'b0; nak = 1'b0; ack = 1'b0; cancel = 1'b0; bad = 1'b0;
    plen = '0; off = '0; psum = '0; ssum = '0;
    case (q_item.cmd)
      xmr_pkg::CMD_START: begin
        bc_nxt = '0; lp_nxt = 1'b0; hc_nxt = '0; hs_nxt = '0; hi_nxt = '0;
        es_nxt = 8'd1; gt_nxt = '0; pt_nxt = '0; tc_nxt = '0; ec_nxt = '0;
        rc_nxt = '0; kc_nxt = '0;
        poc = 1'b1;
      end
      xmr_pkg::CMD_BYTE: begin
        if (phase_r == PH_POLL) begin
          gt_nxt = '0;
          if (q_item.b == xmr_pkg::B_SOH || q_item.b == xmr_pkg::B_STX) begin
            hc_nxt = q_item.b;
            lp_nxt = (q_item.b == xmr_pkg::B_STX);
            rc_nxt = '0;
            bc_nxt = 11'd1;
            phase_nxt = PH_RECV;
          end else begin
            poc = 1'b1;
          end
        end else if (phase_r == PH_RECV) begin
          tc_nxt = '0;
          gt_nxt = '0;
          if (bc_r < 11'd3) begin
            if (bc_r == 11'd0) begin
              hc_nxt = q_item.b;
              rc_nxt = '0;
            end else if (bc_r == 11'd1) begin
              hs_nxt = q_item.b;
            end else begin
              hi_nxt = q_item.b;
            end
            if (hc_nxt == xmr_pkg::B_SOH || hc_nxt == xmr_pkg::B_STX) begin
              lp_nxt = (hc_nxt == xmr_pkg::B_STX);
            end
          end else begin
            off = bc_r - 11'd3;
            if (off < (lp_r ? 11'(xmr_pkg::LONG_PAYLOAD) : 11'(xmr_pkg::SHORT_PAYLOAD))) begin
              o.data_valid = 1'b1;
              o.data_byte = q_item.b;
              o.data_offset = off[9:0];
              o.packet_long = lp_r;
              rc_nxt = xmr_pkg::crc_byte(rc_r, q_item.b);
            end else begin
              kc_nxt = {kc_r[7:0], q_item.b};
            end
          end
          if (bc_r == 11'd0 && q_item.b == xmr_pkg::B_EOT) begin
            o.tx_valid = 1'b1;
            o.tx_byte = xmr_pkg::B_ACK;
            o.session_done = 1'b1;
            phase_nxt = PH_OFF;
          end else begin
            bc_nxt = bc_r + 11'd1;
            plen = lp_nxt ? 11'(xmr_pkg::LONG_PAYLOAD) : 11'(xmr_pkg::SHORT_PAYLOAD);
            if (bc_nxt >= plen + 11'd5) begin
              o.packet_long = lp_nxt;
              ssum = {1'b0, hs_nxt} + {1'b0, hi_nxt};
              if (hc_nxt != (lp_nxt ? xmr_pkg::B_STX : xmr_pkg::B_SOH) ||
                  ssum != 9'd255) begin
                bad = 1'b1;
              end else if (hs_nxt == es_r - 8'd1) begin
                o.packet_status = xmr_pkg::ST_DUP;
                ack = 1'b1;
              end else if (hs_nxt != es_r || rc_nxt != kc_nxt) begin
                bad = 1'b1;
              end else begin
                es_nxt = es_r + 8'd1;
                o.packet_status = xmr_pkg::ST_NEW;
                ack = 1'b1;
              end
            end
          end
        end
      end
      xmr_pkg::CMD_TICK: begin
        if (phase_r != PH_OFF && gt_r < xmr_pkg::GAP_MAX) gt_nxt = gt_r + 20'd1;
        if (phase_r == PH_POLL) begin
          if (gt_nxt >= {4'd0, cfg.poll_interval}) begin
            psum = {1'b0, pt_r} + {6'd0, cfg.poll_interval};
            pt_nxt = (psum > {1'b0, xmr_pkg::POLL_MAX}) ? xmr_pkg::POLL_MAX : psum[20:0];
            poc = 1'b1;
          end
        end else if (phase_r == PH_RECV) begin
          if (gt_nxt >= {4'd0, (bc_r == 11'd0) ? cfg.packet_gap_timeout
                                                : cfg.char_gap_timeout}) begin
            gt_nxt = '0;
            if (tc_r != 4'd15) tc_nxt = tc_r + 4'd1;
            o.packet_status = xmr_pkg::ST_TIMEOUT;
            nak = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (bad) begin
      if (ec_r != 4'd15) ec_nxt = ec_r + 4'd1;
      o.packet_status = xmr_pkg::ST_REJECT;
      nak = 1'b1;
    end
    if (ack) begin
      o.tx_valid = 1'b1; o.tx_byte = xmr_pkg::B_ACK;
      gt_nxt = '0; ec_nxt = '0; bc_nxt = '0;
    end
    if (nak) begin
      if (ec_nxt >= cfg.retry_limit || tc_nxt >= cfg.retry_limit) begin
        cancel = 1'b1;
      end else begin
        o.tx_valid = 1'b1; o.tx_byte = xmr_pkg::B_NAK;
        bc_nxt = '0; gt_nxt = '0;
      end
    end
    if (poc) begin
      if (pt_nxt >= {1'b0, cfg.start_wait_limit}) begin
        cancel = 1'b1;
      end else begin
        o.tx_valid = 1'b1; o.tx_byte = xmr_pkg::B_POLL;
        gt_nxt = '0; phase_nxt = PH_POLL;
      end
    end
    if (cancel) begin
      o.tx_valid = 1'b1; o.tx_byte = xmr_pkg::B_CAN;
      o.session_failed = 1'b1;
      gt_nxt = '0; phase_nxt = PH_OFF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OFF; bc_r <= '0; lp_r <= 1'b0; hc_r <= '0; hs_r <= '0;
      hi_r <= '0; es_r <= 8'd1; gt_r <= '0; pt_r <= '0; tc_r <= '0; ec_r <= '0;
      rc_r <= '0; kc_r <= '0; ov_r <= 1'b0;
    end else begin
      if (fire) begin
        phase_r <= phase_nxt; bc_r <= bc_nxt; lp_r <= lp_nxt; hc_r <= hc_nxt;
        hs_r <= hs_nxt; hi_r <= hi_nxt; es_r <= es_nxt; gt_r <= gt_nxt;
        pt_r <= pt_nxt; tc_r <= tc_nxt; ec_r <= ec_nxt; rc_r <= rc_nxt;
        kc_r <= kc_nxt;
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
    if (fire) res_r <= o;
  end

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && out_stall |=> ov_r && $stable(res_r)) else $error("result lost under stall");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> !(res_r.session_done && res_r.session_failed)) else $error("done and failed");
  a_can: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && res_r.session_failed |-> res_r.tx_byte == xmr_pkg::B_CAN)
    else $error("failure without CAN");
`endif
endmodule

>>> tb/tb_top.sv
// Testbench for the XMODEM-1K receiver: directed and random sessions checked against a cycle-free predictor
module tb_top;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  typedef enum logic [1:0] {PH_OFF, PH_POLL, PH_RECV} rx_phase_t;

  typedef struct packed {
    logic [1:0] req;
    logic [7:0] b;
  } req_item_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_req_type;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic        out_tx_valid;
  logic [7:0]  out_tx_byte;
  logic        out_data_valid;
  logic [7:0]  out_data_byte;
  logic [9:0]  out_data_offset;
  logic [2:0]  out_packet_status;
  logic        out_packet_long;
  logic        out_session_done;
  logic        out_session_failed;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  xmodem_1k_receiver i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_tx_valid(out_tx_valid), .out_tx_byte(out_tx_byte),
    .out_data_valid(out_data_valid), .out_data_byte(out_data_byte),
    .out_data_offset(out_data_offset), .out_packet_status(out_packet_status),
    .out_packet_long(out_packet_long), .out_session_done(out_session_done),
    .out_session_failed(out_session_failed),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // receiver settings and session state of the predictor
  logic [15:0] m_poll_interval;
  logic [19:0] m_start_wait;
  logic [15:0] m_pkt_gap;
  logic [15:0] m_char_gap;
  logic [3:0]  m_retry;
  rx_phase_t   m_phase;
  logic [10:0] m_count;
  logic        m_long;
  logic [7:0]  m_ctrl;
  logic [7:0]  m_seq;
  logic [7:0]  m_seq_inv;
  logic [7:0]  m_exp_seq;
  logic [19:0] m_gap;
  logic [20:0] m_poll_total;
  logic [3:0]  m_timeouts;
  logic [3:0]  m_errors;
  logic [15:0] m_crc;
  logic [15:0] m_rx_crc;

  req_item_t        pending_reqs[$];
  xmr_pkg::result_t expected_replies[$];
  int        fail_count;
  int        transfers_in;
  int        quiet_cycles;
  int        hold_left;
  bit        hold_done;
  bit        calm;
  bit        in_taken;

  function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb  = crc[15] ^ b[i];
      crc = {crc[14:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
    end
    return crc;
  endfunction

  function automatic void clear_session();
    m_count = '0; m_long = 1'b0; m_ctrl = '0; m_seq = '0; m_seq_inv = '0;
    m_exp_seq = 8'd1; m_gap = '0; m_poll_total = '0; m_timeouts = '0;
    m_errors = '0; m_crc = '0; m_rx_crc = '0;
  endfunction

  function automatic void reply(ref xmr_pkg::result_t r, input logic [7:0] b);
    r.tx_valid = 1'b1;
    r.tx_byte  = b;
  endfunction

  function automatic void send_cancel(ref xmr_pkg::result_t r);
    reply(r, xmr_pkg::B_CAN);
    r.session_failed = 1'b1;
    m_gap   = '0;
    m_phase = PH_OFF;
  endfunction

  function automatic void poll_or_cancel(ref xmr_pkg::result_t r);
    if (m_poll_total >= m_start_wait) begin
      send_cancel(r);
    end else begin
      reply(r, xmr_pkg::B_POLL);
      m_gap   = '0;
      m_phase = PH_POLL;
    end
  endfunction

  function automatic void send_ack(ref xmr_pkg::result_t r);
    reply(r, xmr_pkg::B_ACK);
    m_gap = '0; m_errors = '0; m_count = '0;
  endfunction

  function automatic void send_nak(ref xmr_pkg::result_t r);
    if (m_errors >= m_retry || m_timeouts >= m_retry) begin
      send_cancel(r);
    end else begin
      reply(r, xmr_pkg::B_NAK);
      m_count = '0;
      m_gap   = '0;
    end
  endfunction

  function automatic void reject_packet(ref xmr_pkg::result_t r);
    if (m_errors != 4'hF) m_errors++;
    r.packet_status = xmr_pkg::ST_REJECT;
    send_nak(r);
  endfunction

  function automatic void judge_packet(ref xmr_pkg::result_t r);
    logic [7:0] want;
    logic [8:0] sum;
    want = m_long ? xmr_pkg::B_STX : xmr_pkg::B_SOH;
    sum  = {1'b0, m_seq} + {1'b0, m_seq_inv};
    r.packet_long = m_long;
    if (m_ctrl != want || sum != 9'd255) begin
      reject_packet(r);
    end else if (m_seq == m_exp_seq - 8'd1) begin
      r.packet_status = xmr_pkg::ST_DUP;
      send_ack(r);
    end else if (m_seq != m_exp_seq || m_crc != m_rx_crc) begin
      reject_packet(r);
    end else begin
      m_exp_seq++;
      r.packet_status = xmr_pkg::ST_NEW;
      send_ack(r);
    end
  endfunction

  function automatic void packet_byte(ref xmr_pkg::result_t r, input logic [7:0] b);
    int plen;
    int off;
    plen = m_long ? xmr_pkg::LONG_PAYLOAD : xmr_pkg::SHORT_PAYLOAD;
    m_timeouts = '0;
    m_gap      = '0;
    if (m_count < 3) begin
      if (m_count == 0) begin
        m_ctrl = b;
        m_crc  = '0;
        if (b == xmr_pkg::B_EOT) begin
          reply(r, xmr_pkg::B_ACK);
          r.session_done = 1'b1;
          m_phase = PH_OFF;
          return;
        end
      end else if (m_count == 1) begin
        m_seq = b;
      end else begin
        m_seq_inv = b;
      end
      if (m_ctrl == xmr_pkg::B_SOH || m_ctrl == xmr_pkg::B_STX) begin
        m_long = (m_ctrl == xmr_pkg::B_STX);
        plen   = m_long ? xmr_pkg::LONG_PAYLOAD : xmr_pkg::SHORT_PAYLOAD;
      end
    end else begin
      off = int'(m_count) - 3;
      if (off < plen) begin
        r.data_valid  = 1'b1;
        r.data_byte   = b;
        r.data_offset = off[9:0];
        r.packet_long = m_long;
        m_crc = crc16_update(m_crc, b);
      end else begin
        m_rx_crc = {m_rx_crc[7:0], b};
      end
    end
    m_count++;
    if (int'(m_count) >= plen + 5) judge_packet(r);
  endfunction

  function automatic xmr_pkg::result_t receiver_step(logic [1:0] req, logic [7:0] b);
    xmr_pkg::result_t r;
    int      total;
    int      lim;
    r = '0;
    if (req == xmr_pkg::REQ_START) begin
      clear_session();
      poll_or_cancel(r);
    end else if (req == xmr_pkg::REQ_BYTE) begin
      if (m_phase == PH_POLL) begin
        m_gap = '0;
        if (b == xmr_pkg::B_SOH || b == xmr_pkg::B_STX) begin
          m_ctrl  = b;
          m_long  = (b == xmr_pkg::B_STX);
          m_crc   = '0;
          m_count = 11'd1;
          m_phase = PH_RECV;
        end else begin
          poll_or_cancel(r);
        end
      end else if (m_phase == PH_RECV) begin
        packet_byte(r, b);
      end
    end else if (req == xmr_pkg::REQ_TICK) begin
      if (m_phase != PH_OFF && m_gap != xmr_pkg::GAP_MAX) m_gap++;
      if (m_phase == PH_POLL) begin
        if (m_gap >= m_poll_interval) begin
          total = int'(m_poll_total) + int'(m_poll_interval);
          m_poll_total = (total > int'(xmr_pkg::POLL_MAX)) ? xmr_pkg::POLL_MAX : total[20:0];
          poll_or_cancel(r);
        end
      end else if (m_phase == PH_RECV) begin
        lim = (m_count == 0) ? int'(m_pkt_gap) : int'(m_char_gap);
        if (int'(m_gap) >= lim) begin
          m_gap = '0;
          if (m_timeouts != 4'hF) m_timeouts++;
          r.packet_status = xmr_pkg::ST_TIMEOUT;
          send_nak(r);
        end
      end
    end
    return r;
  endfunction

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // sample both channels; check results and predict on input transfers
  always @(posedge clk) begin
    xmr_pkg::result_t e;
    if (rst_n) begin
      in_taken <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count++;
        end else begin
          e = expected_replies.pop_front();
          check_field("tx_valid", e.tx_valid, out_tx_valid);
          check_field("tx_byte", e.tx_byte, out_tx_byte);
          check_field("data_valid", e.data_valid, out_data_valid);
          check_field("data_byte", e.data_byte, out_data_byte);
          check_field("data_offset", e.data_offset, out_data_offset);
          check_field("packet_status", e.packet_status, out_packet_status);
          check_field("packet_long", e.packet_long, out_packet_long);
          check_field("session_done", e.session_done, out_session_done);
          check_field("session_failed", e.session_failed, out_session_failed);
        end
      end
      if (in_valid && !in_stall) begin
        expected_replies.push_back(receiver_step(in_req_type, in_rx_byte));
        transfers_in++;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[xmodem_1k_receiver] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  always @(negedge clk) begin
    req_item_t it;
    if (rst_n && (!in_valid || in_taken)) begin
      if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 34)) begin
        it = pending_reqs.pop_front();
        in_req_type <= it.req;
        in_rx_byte  <= it.b;
        in_valid    <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!hold_done && transfers_in >= 300) begin
      hold_done = 1'b1;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 34);
    end
  end

  task automatic push_req(logic [1:0] req, logic [7:0] b);
    pending_reqs.push_back('{req: req, b: b});
  endtask

  task automatic push_ticks(int n);
    repeat (n) push_req(xmr_pkg::REQ_TICK, 8'($urandom));
  endtask

  task automatic push_packet(bit lng, logic [7:0] seq, int fault, int tick_max, int cut_max);
    logic [15:0] crc;
    logic [7:0]  b;
    int          plen;
    int          cut;
    plen = lng ? xmr_pkg::LONG_PAYLOAD : xmr_pkg::SHORT_PAYLOAD;
    crc  = '0;
    cut  = (fault == 4) ? $urandom_range(cut_max, 1) : -1;
    for (int i = 0; i < plen + 5; i++) begin
      if (i == cut) begin
        push_ticks(tick_max + 1);
        return;
      end
      if (i == 0) b = (fault == 1) ? 8'($urandom) : (lng ? xmr_pkg::B_STX : xmr_pkg::B_SOH);
      else if (i == 1) b = seq;
      else if (i == 2) b = (fault == 2) ? ~seq ^ 8'($urandom_range(255, 1)) : ~seq;
      else if (i < plen + 3) begin
        b   = 8'($urandom);
        crc = crc16_update(crc, b);
      end else if (i == plen + 3) b = crc[15:8] ^ ((fault == 3) ? 8'h01 : 8'h00);
      else b = crc[7:0];
      if (i == 0 && b == xmr_pkg::B_EOT) b = 8'hFF;
      push_req(xmr_pkg::REQ_BYTE, b);
      if ($urandom_range(15) == 0) push_ticks($urandom_range(tick_max));
    end
  endtask

  task automatic push_session(bit lng, int tick_max, int max_pk);
    logic [7:0] seq;
    logic [7:0] sel;
    int         fault;
    int         cut_max;
    seq = 8'd1;
    cut_max = (lng ? xmr_pkg::LONG_PAYLOAD : xmr_pkg::SHORT_PAYLOAD) + 4;
    push_req(xmr_pkg::REQ_START, 8'($urandom));
    if ($urandom_range(2) == 0) push_ticks($urandom_range(tick_max));
    if ($urandom_range(3) == 0) push_req(xmr_pkg::REQ_BYTE, 8'($urandom_range(255, 3)));
    repeat ($urandom_range(max_pk, 1)) begin
      if ($urandom_range(9) == 0) push_req(2'($urandom), 8'($urandom));
      fault = ($urandom_range(9) < 6) ? 0 : $urandom_range(4, 1);
      case ($urandom_range(5))
        0:       sel = seq - 8'd1;
        1:       sel = 8'($urandom);
        default: sel = seq;
      endcase
      push_packet(lng, sel, fault, tick_max, cut_max);
      if (fault == 0 && sel == seq) seq++;
    end
    if ($urandom_range(4) != 0) push_req(xmr_pkg::REQ_BYTE, xmr_pkg::B_EOT);
  endtask

  task automatic settle();
    wait (pending_reqs.size() == 0 && !in_valid && expected_replies.size() == 0);
    repeat (5) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      xmr_pkg::RA_POLL:     m_poll_interval = val[15:0];
      xmr_pkg::RA_WAIT:     m_start_wait    = val[19:0];
      xmr_pkg::RA_PKT_GAP:  m_pkt_gap       = val[15:0];
      xmr_pkg::RA_CHAR_GAP: m_char_gap      = val[15:0];
      xmr_pkg::RA_RETRY:    m_retry         = val[3:0];
      default: ;
    endcase
  endtask

  task automatic cfg_all(int pi, int sw, int pg, int cg, int rl);
    cfg_write(xmr_pkg::RA_POLL, pi);
    cfg_write(xmr_pkg::RA_WAIT, sw);
    cfg_write(xmr_pkg::RA_PKT_GAP, pg);
    cfg_write(xmr_pkg::RA_CHAR_GAP, cg);
    cfg_write(xmr_pkg::RA_RETRY, rl);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0; in_req_type = '0; in_rx_byte = '0;
    out_stall = 1'b0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    fail_count = 0; transfers_in = 0; quiet_cycles = 0;
    hold_left = 0; hold_done = 1'b0; calm = 1'b0; in_taken = 1'b0;
    m_poll_interval = 16'd3000; m_start_wait = 20'd60000;
    m_pkt_gap = 16'd500; m_char_gap = 16'd100; m_retry = 4'd10;
    m_phase = PH_OFF;
    clear_session();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // idle block, unknown request, restart, wrong start byte, EOT
    push_req(REQ_UNKNOWN, 8'hFF);
    push_req(xmr_pkg::REQ_BYTE, 8'hFF);
    push_req(xmr_pkg::REQ_TICK, 8'h00);
    push_req(xmr_pkg::REQ_START, 8'h00);
    push_req(xmr_pkg::REQ_TICK, 8'hAA);
    push_req(xmr_pkg::REQ_BYTE, 8'h00);
    push_req(xmr_pkg::REQ_BYTE, xmr_pkg::B_EOT);
    push_req(xmr_pkg::REQ_BYTE, xmr_pkg::B_STX);
    push_req(xmr_pkg::REQ_BYTE, 8'h01);
    push_req(xmr_pkg::REQ_BYTE, 8'hFE);
    push_req(xmr_pkg::REQ_START, 8'hFF);
    push_req(xmr_pkg::REQ_BYTE, xmr_pkg::B_SOH);
    push_req(xmr_pkg::REQ_BYTE, 8'h00);
    push_req(xmr_pkg::REQ_BYTE, 8'hFF);
    push_req(xmr_pkg::REQ_BYTE, 8'h55);
    push_req(xmr_pkg::REQ_START, 8'h55);
    push_req(xmr_pkg::REQ_BYTE, xmr_pkg::B_SOH);
    push_req(xmr_pkg::REQ_BYTE, xmr_pkg::B_EOT);
    push_req(REQ_UNKNOWN, 8'h00);
    settle();

    cfg_all(2, 9, 3, 3, 2);
    push_session(1'b0, 4, 2);
    settle();

    cfg_all(1, 0, 1, 1, 1);
    push_session(1'b0, 2, 1);
    settle();

    calm = 1'b1;
    cfg_all(65535, 1048575, 65535, 65535, 15);
    push_session(1'b0, 3, 2);
    settle();
    calm = 1'b0;

    // long packets cut short by a timeout
    cfg_all(4, 40, 6, 5, 4);
    push_req(xmr_pkg::REQ_START, 8'h00);
    repeat (3) push_packet(1'b1, 8'd1, 4, 6, 60);
    push_req(xmr_pkg::REQ_BYTE, xmr_pkg::B_EOT);
    settle();

    while (transfers_in < 1000) begin
      push_session(1'b0, 6, 1);
      settle();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("[xmodem_1k_receiver] OK");
    end else begin
      $display("[xmodem_1k_receiver] ERROR");
    end
    $finish;
  end
endmodule
